### src/prime_enumerator_trial_division_unit_defines.svh
// Assertion macros shared by the RTL files of the prime enumerator.
// Define NO_ASSERTIONS to compile them away.
`ifndef PRIME_ENUMERATOR_TRIAL_DIVISION_UNIT_DEFINES_SVH
`define PRIME_ENUMERATOR_TRIAL_DIVISION_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PETD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PETD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PETD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PETD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/petd_pkg.sv
package petd_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_REPLY
   } state_type;

   // Status of the shared divider, seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### src/petd_divider.sv
// Restoring divider, one quotient bit per cycle.
module petd_divider #(
   parameter int WIDTH = petd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WIDTH-1:0]         dividend,
   input  logic [WIDTH-1:0]         divisor,
   output petd_pkg::div_status_type status,
   output logic [WIDTH-1:0]         quotient,
   output logic [WIDTH-1:0]         remainder
);

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] rem_ff, quo_ff, dvs_ff;
   logic [CW-1:0]    count_ff;
   logic             busy_ff, done_ff;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(WIDTH - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not go negative
         if (!diff[WIDTH]) begin
            rem_ff <= diff[WIDTH-1:0];
            quo_ff <= {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[WIDTH-1:0];
            quo_ff <= {quo_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

### src/prime_enumerator_trial_division_unit.sv
// Prime enumerator by trial division.
// Each request on req_ (restart bit) returns one response on rsp_: the next
// prime below the limit, or rsp_done_res = 1 with rsp_prime_value = 0 once
// the kept candidate reaches the limit. restart = 1 rewinds the candidate to
// zero first. The user must write the limit through csr_ only while the block
// is idle; the block itself does not enforce this. A request scans candidates
// upward: even numbers and values below four are settled in the scan step,
// and each odd candidate is divided by every odd trial divisor from 3 up to
// its square root on the one shared restoring divider (one quotient bit per
// cycle), stopping early at a divisor that leaves no remainder. The block
// takes one request at a time: req_ready is high only while idle.
// The response sits in an output register; if the receiver stalls, the next
// search still runs and waits in the reply step until the register frees.
// Synchronous reset clears the limit and the candidate to zero and drops any
// pending response.
`include "prime_enumerator_trial_division_unit_defines.svh"

module prime_enumerator_trial_division_unit #(
   parameter int VALUE_BITS = petd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_restart,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_prime_value,
   output logic                  rsp_done_res,
   // limit register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [VALUE_BITS-1:0] csr_upper_limit
);

   localparam int N = VALUE_BITS;

   petd_pkg::state_type state_ff, state_in;

   logic [N-1:0] limit_ff;
   logic [N-1:0] cand_ff, cand_in;        // next candidate to test
   logic [N-1:0] dvs_ff, dvs_in;          // current odd trial divisor
   logic [N-1:0] res_prime_ff, res_prime_in;
   logic         res_done_ff, res_done_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [N-1:0] rsp_prime_ff, rsp_prime_in;
   logic         rsp_done_ff, rsp_done_in;

   logic                     div_start;
   petd_pkg::div_status_type div_status;
   logic [N-1:0]             div_quotient;
   logic [N-1:0]             div_remainder;

   // The divider latches its operands on start, so hand it the divisor
   // that is being loaded in the same cycle.
   petd_divider #(
      .WIDTH (N)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   (dvs_in),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Limit register: always ready; the user must write it only while idle, the block itself does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid) begin
         limit_ff <= csr_upper_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= petd_pkg::ST_IDLE;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cand_ff      <= cand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff       <= dvs_in;
      res_prime_ff <= res_prime_in;
      res_done_ff  <= res_done_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      dvs_in       = dvs_ff;
      res_prime_in = res_prime_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;   // drop once taken
      rsp_prime_in = rsp_prime_ff;
      rsp_done_in  = rsp_done_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         petd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart) begin
                  cand_in = '0;
               end
               state_in = petd_pkg::ST_SCAN;
            end
         end

         petd_pkg::ST_SCAN: begin
            if (cand_ff >= limit_ff) begin
               // limit reached: answer done, hold the candidate
               res_prime_in = '0;
               res_done_in  = 1'b1;
               state_in     = petd_pkg::ST_REPLY;
            end else if (cand_ff < N'(2)) begin
               cand_in = cand_ff + 1'b1;
            end else if (cand_ff < N'(4)) begin
               res_prime_in = cand_ff;
               res_done_in  = 1'b0;
               cand_in      = cand_ff + 1'b1;
               state_in     = petd_pkg::ST_REPLY;
            end else if (!cand_ff[0]) begin
               cand_in = cand_ff + 1'b1;
            end else begin
               dvs_in    = N'(3);
               div_start = 1'b1;
               state_in  = petd_pkg::ST_DIVIDE;
            end
         end

         petd_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               if (div_quotient < dvs_ff) begin
                  // divisor passed the square root: prime
                  res_prime_in = cand_ff;
                  res_done_in  = 1'b0;
                  cand_in      = cand_ff + 1'b1;
                  state_in     = petd_pkg::ST_REPLY;
               end else if (div_remainder == '0) begin
                  cand_in  = cand_ff + 1'b1;
                  state_in = petd_pkg::ST_SCAN;
               end else begin
                  dvs_in    = dvs_ff + N'(2);
                  div_start = 1'b1;
               end
            end
         end

         petd_pkg::ST_REPLY: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_prime_ff;
               rsp_done_in  = res_done_ff;
               state_in     = petd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = petd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_prime_ff;
   assign rsp_done_res    = rsp_done_ff;

   `PETD_ASSERT_IMPLY(a_start_idle, clock, reset, div_start, !div_status.busy, "divider restarted while busy")
   `PETD_ASSERT_IMPLY(a_done_zero, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_prime_ff == '0, "done response carries a value")
   `PETD_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_valid && req_ready, state_ff == petd_pkg::ST_SCAN, "accepted request did not start a scan")
   `PETD_ASSERT_IMPLY(a_odd_divisor, clock, reset, state_ff == petd_pkg::ST_DIVIDE, dvs_ff[0] && cand_ff[0], "even divisor or candidate in trial division")

endmodule

### bench/prime_enumerator_trial_division_unit_tb.sv
module prime_enumerator_trial_division_unit_tb;

   localparam int VBITS       = petd_pkg::VALUE_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [VBITS-1:0] LIMIT_MAX = '1;

   // One expected response: the prime handed out, or the done flag.
   typedef struct packed {
      logic [VBITS-1:0] prime_value;
      logic             done_flag;
   } prime_reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_restart = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VBITS-1:0] rsp_prime_value;
   logic             rsp_done_res;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [VBITS-1:0] csr_upper_limit = '0;

   // Restart bits of the requests still to be sent, and the replies owed.
   logic             pending_restarts[$];
   prime_reply_type  prime_expect[$];

   // Shadow copies of the limit register and the kept candidate.
   logic [VBITS-1:0] limit_model = '0;
   logic [VBITS-1:0] candidate_model = '0;

   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               random_requests = 0;
   bit               req_hs = 1'b0;

   prime_enumerator_trial_division_unit #(
      .VALUE_BITS(VBITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_upper_limit (csr_upper_limit)
   );

   always #1 clock = ~clock;

   // Trial division up to the square root; odd divisors only.
   function automatic bit is_prime_number(input longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if ((n % 2) == 0) return 1'b0;
      for (d = 3; d * d <= n; d += 2)
         if ((n % d) == 0) return 1'b0;
      return 1'b1;
   endfunction

   // Scan upward from the kept candidate for the next prime below the limit
   // and queue the reply that the request must produce.
   task automatic predict_next_prime(input logic restart);
      prime_reply_type reply;
      longint unsigned cand;
      if (restart) candidate_model = '0;
      cand = candidate_model;
      reply.prime_value = '0;
      reply.done_flag = 1'b1;
      while (reply.done_flag && cand < limit_model) begin
         if (is_prime_number(cand)) begin
            reply.prime_value = cand[VBITS-1:0];
            reply.done_flag = 1'b0;
         end
         cand++;
      end
      // On done the candidate stays put unless the scan walked up to the limit.
      candidate_model = cand[VBITS-1:0];
      prime_expect.push_back(reply);
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Driver: change inputs on the falling edge; hold a request until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_hs) begin
         if (pending_restarts.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_valid   <= 1'b1;
            req_restart <= pending_restarts.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall the response channel at random.
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Monitor: sample on the rising edge. Track limit writes and accepted
   // requests in the shadow state, then check each accepted response
   // against the oldest reply owed.
   always @(posedge clock) begin
      prime_reply_type got;
      prime_reply_type want;
      req_hs = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) limit_model = csr_upper_limit;
         if (req_valid && req_ready) begin
            req_hs = 1'b1;
            predict_next_prime(req_restart);
         end
         if (rsp_valid && rsp_ready) begin
            got.prime_value = rsp_prime_value;
            got.done_flag   = rsp_done_res;
            if (prime_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected response prime %0d done %0b",
                                         got.prime_value, got.done_flag));
            end else begin
               want = prime_expect.pop_front();
               if (got.prime_value !== want.prime_value)
                  report_mismatch($sformatf("prime_value got %0d want %0d",
                                            got.prime_value, want.prime_value));
               if (got.done_flag !== want.done_flag)
                  report_mismatch($sformatf("done_res got %0b want %0b",
                                            got.done_flag, want.done_flag));
            end
         end
      end
   end

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("prime_enumerator_trial_division_unit regression: fail");
         $finish;
      end
   end

   // Block until every request is sent and every reply has come back.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (pending_restarts.size() != 0 || req_valid || prime_expect.size() != 0);
   endtask

   // Receiver-heavy gaps first, then sender-heavy gaps, then none.
   task automatic next_idle_mode();
      if (random_requests < 40) begin
         req_idle_pct = 32;
         rsp_idle_pct = 79;
      end else if (random_requests < 80) begin
         req_idle_pct = 79;
         rsp_idle_pct = 32;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endtask

   // Drain, then write the limit with the block idle.
   task automatic start_phase(input logic [VBITS-1:0] limit);
      wait_for_idle();
      next_idle_mode();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_upper_limit <= limit;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_restarts(input int count, input logic restart_bit);
      repeat (count) pending_restarts.push_back(restart_bit);
   endtask

   initial begin
      logic [VBITS-1:0] limit;
      int               pick;
      int               count;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Limit still zero after reset: answer done either way.
      next_idle_mode();
      queue_restarts(1, 1'b0);
      queue_restarts(1, 1'b1);

      // Limit 2: 0 and 1 are not prime, so done and the candidate ends at 2.
      start_phase(VBITS'(2));
      queue_restarts(1, 1'b1);

      // Raise to 3: continue from the kept candidate and find 2, then done.
      start_phase(VBITS'(3));
      queue_restarts(2, 1'b0);

      // Walk all primes below 20, then stay done at the limit.
      start_phase(VBITS'(20));
      queue_restarts(1, 1'b1);
      queue_restarts(9, 1'b0);

      // Lower the limit below the candidate: done at once; restart finds 2.
      start_phase(VBITS'(5));
      queue_restarts(1, 1'b0);
      queue_restarts(1, 1'b1);

      // Widest limit: every register bit high.
      start_phase(LIMIT_MAX);
      queue_restarts(2, 1'b0);
      queue_restarts(1, 1'b1);

      // Zero limit with a live candidate.
      start_phase('0);
      queue_restarts(1, 1'b0);

      // Random phases: mostly modest limits so the divider loop stays short,
      // with the odd tiny, full-width, random-width or lowered limit.
      while (random_requests < 120) begin
         pick = $urandom_range(9);
         if (pick < 6)
            limit = VBITS'($urandom_range(2, 3000));
         else if (pick == 6)
            limit = VBITS'($urandom_range(0, 3));
         else if (pick == 7)
            limit = LIMIT_MAX;
         else if (pick == 8)
            limit = VBITS'($urandom());
         else
            limit = VBITS'($urandom_range(0, 40));
         start_phase(limit);
         count = $urandom_range(4, 20);
         for (int i = 0; i < count; i++)
            pending_restarts.push_back(($urandom_range(5) == 0) ||
                                       (i == 0 && $urandom_range(1) == 1));
         random_requests += count;
      end

      wait_for_idle();
      // Let any stray response show up before judging.
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && prime_expect.size() == 0)
         $display("prime_enumerator_trial_division_unit regression: pass");
      else
         $display("prime_enumerator_trial_division_unit regression: fail");
      $finish;
   end

endmodule
